// ----- rtl/core/ramr_pkg.sv -----
// ----------------------------------------------------------------------------
// ramr_pkg
// shared types, codes and microcode program for the rational add/mul/reduce core
// ----------------------------------------------------------------------------
package ramr_pkg;

  localparam int unsigned ACTION_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MUL    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REDUCE = 2'd2;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_MUL_T1,
    OP_MUL_T2,
    OP_MUL_DEN,
    OP_COMBINE,
    OP_STRIP_COMMON,
    OP_STRIP_A,
    OP_GCD_STEP,
    OP_SCALE,
    OP_DIV_STEP,
    OP_WRITE
  } op_e;

  // jump conditions; C_NEXT always falls through
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD,
    C_MAG_ZERO,
    C_BOTH_EVEN,
    C_A_EVEN,
    C_GCD_MORE,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_e;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic no_input;
    logic bad;
    logic mag_zero;
    logic both_even;
    logic a_even;
    logic gcd_more;
    logic cnt_nz;
    logic out_busy;
  } flags_t;

  // program step addresses
  localparam pc_t S_IDLE         = 4'd0;
  localparam pc_t S_CHECK        = 4'd1;
  localparam pc_t S_MUL_T1       = 4'd2;
  localparam pc_t S_MUL_T2       = 4'd3;
  localparam pc_t S_MUL_DEN      = 4'd4;
  localparam pc_t S_COMBINE      = 4'd5;
  localparam pc_t S_STRIP_COMMON = 4'd6;
  localparam pc_t S_STRIP_A      = 4'd7;
  localparam pc_t S_GCD          = 4'd8;
  localparam pc_t S_SCALE        = 4'd9;
  localparam pc_t S_DIV          = 4'd10;
  localparam pc_t S_WRITE        = 4'd11;
  localparam pc_t S_RETURN       = 4'd12;

  // read-only program store
  function automatic ctrl_t microcode(pc_t pc);
    ctrl_t w;
    case (pc)
      S_IDLE:         w = '{OP_LOAD,         C_NO_INPUT,  S_IDLE};
      S_CHECK:        w = '{OP_CHECK,        C_BAD,       S_WRITE};
      S_MUL_T1:       w = '{OP_MUL_T1,       C_NEXT,      S_IDLE};
      S_MUL_T2:       w = '{OP_MUL_T2,       C_NEXT,      S_IDLE};
      S_MUL_DEN:      w = '{OP_MUL_DEN,      C_NEXT,      S_IDLE};
      S_COMBINE:      w = '{OP_COMBINE,      C_MAG_ZERO,  S_WRITE};
      S_STRIP_COMMON: w = '{OP_STRIP_COMMON, C_BOTH_EVEN, S_STRIP_COMMON};
      S_STRIP_A:      w = '{OP_STRIP_A,      C_A_EVEN,    S_STRIP_A};
      S_GCD:          w = '{OP_GCD_STEP,     C_GCD_MORE,  S_GCD};
      S_SCALE:        w = '{OP_SCALE,        C_NEXT,      S_IDLE};
      S_DIV:          w = '{OP_DIV_STEP,     C_CNT_NZ,    S_DIV};
      S_WRITE:        w = '{OP_WRITE,        C_OUT_BUSY,  S_WRITE};
      S_RETURN:       w = '{OP_NONE,         C_ALWAYS,    S_IDLE};
      default:        w = '{OP_NONE,         C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/ramr_sequencer.sv -----
// ----------------------------------------------------------------------------
// ramr_sequencer
// step counter with conditional jumps over the microcode program
// ----------------------------------------------------------------------------
module ramr_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ramr_pkg::flags_t flags_i,
  output ramr_pkg::ctrl_t  ctrl_o
);

  ramr_pkg::pc_t   pc_q;
  ramr_pkg::pc_t   pc_d;
  ramr_pkg::ctrl_t word;
  logic            take;

  assign word   = ramr_pkg::microcode(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      ramr_pkg::C_NEXT:      take = 1'b0;
      ramr_pkg::C_ALWAYS:    take = 1'b1;
      ramr_pkg::C_NO_INPUT:  take = flags_i.no_input;
      ramr_pkg::C_BAD:       take = flags_i.bad;
      ramr_pkg::C_MAG_ZERO:  take = flags_i.mag_zero;
      ramr_pkg::C_BOTH_EVEN: take = flags_i.both_even;
      ramr_pkg::C_A_EVEN:    take = flags_i.a_even;
      ramr_pkg::C_GCD_MORE:  take = flags_i.gcd_more;
      ramr_pkg::C_CNT_NZ:    take = flags_i.cnt_nz;
      ramr_pkg::C_OUT_BUSY:  take = flags_i.out_busy;
      default:               take = 1'b0;
    endcase
    pc_d = take ? word.target : pc_q + ramr_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ramr_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- rtl/core/rational_add_mul_reduce_core.sv -----
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_core
// adds, multiplies or reduces fractions and brings the result to lowest terms
// ----------------------------------------------------------------------------
// steps: load, check, cross products, denominator product, combine, strip common twos,
//   strip a, gcd loop, scale, divide bit by bit, write; loops repeat as needed, and a zero
//   input denominator jumps from check, a zero result numerator from combine, to write
// handshake: one word at a time; the next is taken after a result is written and the
//   return step is done, and the write step waits while the previous result is unread
// reset: asynchronous active low, clears the step counter and output valid
// ----------------------------------------------------------------------------
module rational_add_mul_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input word
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // left_numerator, left_denominator, right_numerator, right_denominator
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // action
  input  logic [ramr_pkg::ACTION_W-1:0]          s_axis_tuser_i,
  // result word
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // result_numerator, result_denominator, zero padding
  output logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic                                   m_axis_tuser_o
);

  localparam int unsigned W           = OPERAND_WIDTH;
  localparam int unsigned MW          = 2 * W;          // exact product width
  localparam int unsigned NUM_W       = MW + 1;
  localparam int unsigned DEN_W       = MW;
  localparam int unsigned CNT_W       = $clog2(MW);
  localparam int unsigned OUT_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - NUM_W - DEN_W;

  ramr_pkg::ctrl_t  ctrl;
  ramr_pkg::flags_t flags;

  // captured operands
  logic [ramr_pkg::ACTION_W-1:0] act_q;
  logic [W-1:0]  lnum_q, lden_q, rnum_q, rden_q;
  // products and gcd working registers
  logic [MW-1:0] t1_q, t2_q;
  logic [MW-1:0] a_q, b_q, g_q;
  // magnitude and denominator, reused as quotient shift registers
  logic [MW-1:0] mag_q, den_q;
  logic [MW-1:0] rn_q, rd_q;
  logic [CNT_W-1:0] k_q, cnt_q;
  logic neg_q, bad_q, zero_q;

  // output register
  logic             out_valid_q;
  logic [NUM_W-1:0] out_num_q;
  logic [DEN_W-1:0] out_den_q;
  logic             out_status_q;

  // operand magnitudes
  logic         lneg, rneg, is_reduce, bad;
  logic [W-1:0] lmag, rmag;
  logic [W-1:0] mul_x, mul_y;
  logic [MW-1:0] prod;
  logic [MW-1:0] comb_mag;
  logic          comb_neg;
  logic          out_busy, wr_en;

  // divider
  logic [MW:0]   trial_n, trial_d;
  logic          ge_n, ge_d;
  logic [MW:0]   diff_n, diff_d;

  ramr_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // the idle step is the only one that takes a word
  assign s_axis_tready_o = (ctrl.op == ramr_pkg::OP_LOAD);

  assign lneg      = lnum_q[W-1];
  assign rneg      = rnum_q[W-1];
  assign lmag      = lneg ? (~lnum_q + W'(1)) : lnum_q;
  assign rmag      = rneg ? (~rnum_q + W'(1)) : rnum_q;
  assign is_reduce = (act_q != ramr_pkg::ACT_ADD) && (act_q != ramr_pkg::ACT_MUL);
  // reduce only looks at the first denominator; unused code behaves as reduce
  assign bad       = (lden_q == '0) || (!is_reduce && (rden_q == '0));

  // one shared multiplier, operands picked by the current step
  always_comb begin
    case (ctrl.op)
      ramr_pkg::OP_MUL_T1: begin
        mul_x = lmag;
        if (is_reduce) begin
          mul_y = W'(1);
        end else if (act_q == ramr_pkg::ACT_MUL) begin
          mul_y = rmag;
        end else begin
          mul_y = rden_q;
        end
      end
      ramr_pkg::OP_MUL_T2: begin
        mul_x = rmag;
        mul_y = lden_q;
      end
      ramr_pkg::OP_MUL_DEN: begin
        mul_x = lden_q;
        mul_y = is_reduce ? W'(1) : rden_q;
      end
      default: begin
        mul_x = lmag;
        mul_y = rden_q;
      end
    endcase
  end

  assign prod = MW'(mul_x) * MW'(mul_y);

  // add: signed sum of the cross products; multiply and reduce: first product; sign kept apart from the magnitude
  always_comb begin
    if (act_q == ramr_pkg::ACT_ADD) begin
      if (lneg == rneg) begin
        comb_mag = t1_q + t2_q;
        comb_neg = lneg;
      end else if (t1_q >= t2_q) begin
        comb_mag = t1_q - t2_q;
        comb_neg = lneg;
      end else begin
        comb_mag = t2_q - t1_q;
        comb_neg = rneg;
      end
    end else if (act_q == ramr_pkg::ACT_MUL) begin
      comb_mag = t1_q;
      comb_neg = lneg ^ rneg;
    end else begin
      comb_mag = t1_q;
      comb_neg = lneg;
    end
  end

  // restoring division of magnitude and denominator by the gcd, side by side
  assign trial_n = {rn_q, mag_q[MW-1]};
  assign trial_d = {rd_q, den_q[MW-1]};
  assign ge_n    = trial_n >= {1'b0, g_q};
  assign ge_d    = trial_d >= {1'b0, g_q};
  assign diff_n  = trial_n - {1'b0, g_q};
  assign diff_d  = trial_d - {1'b0, g_q};

  assign out_busy = out_valid_q && !m_axis_tready_i;
  assign wr_en    = (ctrl.op == ramr_pkg::OP_WRITE) && !out_busy;

  always_comb begin
    flags.no_input  = !s_axis_tvalid_i;
    flags.bad       = bad;
    flags.mag_zero  = (comb_mag == '0);
    flags.both_even = !a_q[0] && !b_q[0];
    flags.a_even    = !a_q[0];
    // the loop ends on the step that leaves b at zero
    flags.gcd_more  = !(b_q[0] && (a_q == b_q));
    flags.cnt_nz    = (cnt_q != '0);
    flags.out_busy  = out_busy;
  end

  // datapath, driven by the control word
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      ramr_pkg::OP_LOAD: begin
        if (s_axis_tvalid_i) begin
          act_q  <= s_axis_tuser_i;
          lnum_q <= s_axis_tdata_i[W-1:0];
          lden_q <= s_axis_tdata_i[2*W-1:W];
          rnum_q <= s_axis_tdata_i[3*W-1:2*W];
          rden_q <= s_axis_tdata_i[4*W-1:3*W];
        end
      end
      ramr_pkg::OP_CHECK: begin
        bad_q  <= bad;
        zero_q <= 1'b0;
        k_q    <= '0;
      end
      ramr_pkg::OP_MUL_T1: begin
        t1_q <= prod;
      end
      ramr_pkg::OP_MUL_T2: begin
        t2_q <= prod;
      end
      ramr_pkg::OP_MUL_DEN: begin
        b_q   <= prod;
        den_q <= prod;
      end
      ramr_pkg::OP_COMBINE: begin
        a_q    <= comb_mag;
        mag_q  <= comb_mag;
        neg_q  <= comb_neg;
        zero_q <= (comb_mag == '0);
      end
      ramr_pkg::OP_STRIP_COMMON: begin
        if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + CNT_W'(1);
        end
      end
      ramr_pkg::OP_STRIP_A: begin
        if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end
      end
      ramr_pkg::OP_GCD_STEP: begin
        if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= b_q;
          b_q <= a_q - b_q;
        end else begin
          b_q <= b_q - a_q;
        end
      end
      ramr_pkg::OP_SCALE: begin
        g_q   <= a_q << k_q;
        rn_q  <= '0;
        rd_q  <= '0;
        cnt_q <= CNT_W'(MW - 1);
      end
      ramr_pkg::OP_DIV_STEP: begin
        rn_q  <= ge_n ? diff_n[MW-1:0] : trial_n[MW-1:0];
        rd_q  <= ge_d ? diff_d[MW-1:0] : trial_d[MW-1:0];
        mag_q <= {mag_q[MW-2:0], ge_n};
        den_q <= {den_q[MW-2:0], ge_d};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register parts the sequencer from the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_status_q <= bad_q;
      // zero denominator given or zero numerator: fixed 0/1
      if (bad_q || zero_q) begin
        out_num_q <= '0;
        out_den_q <= DEN_W'(1);
      end else begin
        out_num_q <= neg_q ? (NUM_W'(0) - {1'b0, mag_q}) : {1'b0, mag_q};
        out_den_q <= den_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_den_q, out_num_q};
  assign m_axis_tuser_o  = out_status_q;

  // a shown result always has a positive denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_den_q != '0))
    else $error("result denominator is zero");

  // a flagged result carries the fixed 0/1 fraction
  a_bad_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> ((out_num_q == '0) && (out_den_q == DEN_W'(1))))
    else $error("flagged result is not 0/1");

  // one word at a time: the sequencer leaves idle after taking a word
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("word taken while previous one still at work");

  // the divider never runs with a zero divisor
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == ramr_pkg::OP_DIV_STEP) |-> (g_q != '0))
    else $error("division by zero gcd");

endmodule
